// ===== hdl/hamem_pkg.sv =====
// Shared constants and types for the Hebbian associative memory.
package hamem_pkg;

  // Geometry of the weight matrix and the pattern widths.
  localparam int KEY_LEN     = 4;
  localparam int TARGET_LEN  = 3;
  localparam int WEIGHT_BITS = 8;

  // Saturation limits of one weight.
  localparam logic signed [WEIGHT_BITS-1:0] WLIMIT     = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] WLIMIT_NEG =
    {1'b1, {(WEIGHT_BITS-2){1'b0}}, 1'b1};

  // Datapath widths.
  localparam int REC_W  = WEIGHT_BITS + $clog2(KEY_LEN);     // one recall value
  localparam int SQ_W   = 2 * REC_W - 2;                     // square of one recall value
  localparam int X_W    = SQ_W + $clog2(TARGET_LEN);         // squared norm of recall
  localparam int Z_W    = REC_W + $clog2(TARGET_LEN);        // dot product with reference
  localparam int P_W    = X_W + $clog2(TARGET_LEN + 1);      // x times squared reference norm
  localparam int Z2_W   = 2 * (Z_W - 1);                     // square of |z|
  localparam int COS_W  = 16;                                // Q1.15 cosine
  localparam int Q_W    = 16;                                // cosine magnitude search
  localparam int SQT_W  = 2 * Q_W + 2;                       // (2q-1)^2
  localparam int PROD_W = SQT_W + P_W;                       // (2q-1)^2 * p

  // What one lane hands to the merging stage.
  typedef struct packed {
    logic signed [REC_W-1:0] rec;
    logic        [SQ_W-1:0]  sq;
    logic signed [REC_W-1:0] zterm;
  } lane_res_t;

  // Status of the cosine unit toward the top level.
  typedef struct packed {
    logic                    ready;
    logic signed [COS_W-1:0] cosine;
    logic                    zero_norm;
  } cos_res_t;

endpackage

// ===== hdl/hamem_lane.sv =====
// One output lane: a weight column, its Hebbian update and its recall sum.
module hamem_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             train,
  input  logic                             capture,
  input  logic [hamem_pkg::KEY_LEN-1:0]    key_bits,
  input  logic                             tgt_bit,
  output hamem_pkg::lane_res_t             res
);
  import hamem_pkg::*;

  logic signed [WEIGHT_BITS-1:0] weights [KEY_LEN];
  logic signed [REC_W-1:0]       rec;
  logic signed [REC_W-1:0]       rec_next;
  logic                          tgt;
  logic signed [2*REC_W-1:0]     sq_full;
  logic [SQ_W-1:0]               sq;
  logic signed [REC_W-1:0]       zterm;

  always_comb begin
    rec_next = '0;
    for (int i = 0; i < KEY_LEN; i++) begin
      if (key_bits[i]) begin
        rec_next = rec_next + REC_W'(weights[i]);
      end else begin
        rec_next = rec_next - REC_W'(weights[i]);
      end
    end
  end

  // Matching key and target elements raise a weight, differing ones lower it.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_LEN; i++) begin
        weights[i] <= '0;
      end
    end else if (train) begin
      for (int i = 0; i < KEY_LEN; i++) begin
        if (key_bits[i] == tgt_bit) begin
          if (weights[i] != WLIMIT) begin
            weights[i] <= weights[i] + WEIGHT_BITS'(1);
          end
        end else begin
          if (weights[i] != WLIMIT_NEG) begin
            weights[i] <= weights[i] - WEIGHT_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      rec <= rec_next;
      tgt <= tgt_bit;
    end
  end

  assign sq_full = rec * rec;

  always_ff @(posedge clk) begin
    sq    <= sq_full[SQ_W-1:0];
    zterm <= tgt ? rec : -rec;
  end

  assign res.rec   = rec;
  assign res.sq    = sq;
  assign res.zterm = zterm;

endmodule

// ===== hdl/hamem_cosine.sv =====
// Cosine unit: bit-by-bit search of the rounded Q1.15 cosine magnitude.
module hamem_cosine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  ack,
  input  logic        [hamem_pkg::X_W-1:0]      x,
  input  logic signed [hamem_pkg::Z_W-1:0]      z,
  output hamem_pkg::cos_res_t                   res
);
  import hamem_pkg::*;

  localparam logic [2:0] CS_IDLE  = 3'd0;
  localparam logic [2:0] CS_SETUP = 3'd1;
  localparam logic [2:0] CS_TRY   = 3'd2;
  localparam logic [2:0] CS_TEST  = 3'd3;
  localparam logic [2:0] CS_DONE  = 3'd4;

  localparam int K_W = $clog2(Q_W);
  localparam int ACC_W = SQT_W + 6;

  logic [2:0]              state;
  logic [K_W-1:0]          k;
  logic [X_W-1:0]          x_r;
  logic signed [Z_W-1:0]   z_r;
  logic                    zneg;
  logic                    zero_norm;
  logic [P_W-1:0]          p;
  logic [Z2_W-1:0]         z2;
  logic [Q_W-1:0]          q;
  logic [Q_W-1:0]          q_try;
  logic [SQT_W-1:0]        sq;
  logic [SQT_W-1:0]        sq_try;

  logic [Z_W-1:0]          az;
  logic [2*Z_W-1:0]        z2_full;
  logic signed [Q_W+1:0]   d;
  logic signed [ACC_W-1:0] acc;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       rhs;
  logic [Q_W:0]            neg_q;
  logic signed [COS_W-1:0] cos_val;

  assign az      = z_r[Z_W-1] ? -z_r : z_r;
  assign z2_full = az * az;

  // (2q+2^(k+1)-1)^2 built from (2q-1)^2 with shifts and adds.
  assign d   = $signed({1'b0, q, 1'b0}) - (Q_W+2)'(1);
  assign acc = $signed({{(ACC_W-SQT_W){1'b0}}, sq})
             + ({{(ACC_W-Q_W-2){d[Q_W+1]}}, d} <<< ({1'b0, k} + 5'd2))
             + ($signed(ACC_W'(1)) <<< ({2'b0, k, 1'b0} + 7'd2));

  assign prod = PROD_W'(sq_try) * PROD_W'(p);
  assign rhs  = PROD_W'({z2, 32'b0});

  assign neg_q = -{1'b0, q};
  always_comb begin
    if (zero_norm) begin
      cos_val = '0;
    end else if (zneg) begin
      cos_val = neg_q[COS_W-1:0];
    end else if (q[Q_W-1]) begin
      cos_val = {1'b0, {(COS_W-1){1'b1}}};
    end else begin
      cos_val = q[COS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      unique case (state)
        CS_IDLE: begin
          if (start) begin
            state <= (x == '0) ? CS_DONE : CS_SETUP;
          end
        end
        CS_SETUP: state <= CS_TRY;
        CS_TRY:   state <= CS_TEST;
        CS_TEST:  state <= (k == '0) ? CS_DONE : CS_TRY;
        CS_DONE: begin
          if (ack) begin
            state <= CS_IDLE;
          end
        end
        default:  state <= CS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      CS_IDLE: begin
        if (start) begin
          x_r       <= x;
          z_r       <= z;
          zneg      <= z[Z_W-1];
          zero_norm <= (x == '0);
        end
      end
      CS_SETUP: begin
        p  <= P_W'(x_r) * P_W'(TARGET_LEN);
        z2 <= z2_full[Z2_W-1:0];
        q  <= '0;
        sq <= SQT_W'(1);
        k  <= K_W'(Q_W - 1);
      end
      CS_TRY: begin
        sq_try <= acc[SQT_W-1:0];
        q_try  <= q | (Q_W'(1) << k);
      end
      CS_TEST: begin
        if (prod <= rhs) begin
          q  <= q_try;
          sq <= sq_try;
        end
        k <= k - K_W'(1);
      end
      CS_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign res.ready     = (state == CS_DONE);
  assign res.cosine    = cos_val;
  assign res.zero_norm = zero_norm;

endmodule

// ===== hdl/hebbian_associative_memory_top.sv =====
// Top level of the Hebbian associative memory: lanes, merge stage and output register.
// A train transaction updates every weight at the clock edge on which it is accepted.
// A recall result is loaded after the capture register, square, merge, cosine setup and a
// try and test step per search bit (16 bits); an all-zero recall skips setup and search.
// Input stalls while a recall is in flight, until its result is loaded.
// Reset clears all weights at once and leaves the block idle with no result pending.
module hebbian_associative_memory_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   req_type,
  input  logic [hamem_pkg::KEY_LEN-1:0]          key_bits,
  input  logic [hamem_pkg::TARGET_LEN-1:0]       target_bits,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [hamem_pkg::REC_W-1:0]     recall_0,
  output logic signed [hamem_pkg::REC_W-1:0]     recall_1,
  output logic signed [hamem_pkg::REC_W-1:0]     recall_2,
  output logic signed [hamem_pkg::COS_W-1:0]     cosine,
  output logic                                   zero_norm
);
  import hamem_pkg::*;

  // Control sequence for one recall transaction.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SQUARE = 2'd1;
  localparam logic [1:0] ST_MERGE  = 2'd2;
  localparam logic [1:0] ST_COS    = 2'd3;

  logic [1:0]            state;
  logic                  accept;
  logic                  train;
  logic                  capture;
  logic                  cos_start;
  logic                  cos_ack;
  logic                  out_free;
  lane_res_t             lane_res [TARGET_LEN];
  cos_res_t              cres;
  logic [X_W-1:0]        x_sum;
  logic signed [Z_W-1:0] z_sum;

  // The block takes a new transaction only when no recall is in flight. A finished
  // result may still sit in the output register while the next transaction is taken.
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign train    = accept && !req_type;
  assign capture  = accept && req_type;
  assign out_free = !out_valid || !out_stall;

  // One lane per target element: each keeps its own weight column, so a train
  // transaction updates all columns in parallel and a recall sums all columns at once.
  for (genvar j = 0; j < TARGET_LEN; j++) begin : g_lane
    hamem_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .train    (train),
      .capture  (capture),
      .key_bits (key_bits),
      .tgt_bit  (target_bits[j]),
      .res      (lane_res[j])
    );
  end

  // Merge stage: squared norm of the recall vector and its dot product with the reference.
  always_comb begin
    x_sum = '0;
    z_sum = '0;
    for (int j = 0; j < TARGET_LEN; j++) begin
      x_sum = x_sum + X_W'(lane_res[j].sq);
      z_sum = z_sum + Z_W'(lane_res[j].zterm);
    end
  end

  assign cos_start = (state == ST_MERGE);
  assign cos_ack   = (state == ST_COS) && cres.ready && out_free;

  hamem_cosine u_cosine (
    .clk   (clk),
    .rst   (rst),
    .start (cos_start),
    .ack   (cos_ack),
    .x     (x_sum),
    .z     (z_sum),
    .res   (cres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (capture) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: state <= ST_MERGE;
        ST_MERGE:  state <= ST_COS;
        ST_COS: begin
          if (cos_ack) begin
            state <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // Output register: loaded when the cosine is ready and the previous result has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cos_ack) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cos_ack) begin
      recall_0  <= lane_res[0].rec;
      recall_1  <= lane_res[1].rec;
      recall_2  <= lane_res[2].rec;
      cosine    <= cres.cosine;
      zero_norm <= cres.zero_norm;
    end
  end

endmodule
